FILE: hw/rtl/rfc_pkg.sv
// Reciprocal frequency counter: shared widths, register indexes and the
// request/response structs between the top level and the mul/div unit.
// No dependencies.
package rfc_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 8;
	localparam int FREQ_W    = 40;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int NUM_W     = PROD_W + FRAC_W;
	localparam int CFG_IDX_W = 1;
	localparam int MUL_STEPS = DATA_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W    = $clog2(NUM_W);

	localparam logic [DATA_W-1:0] EDGE_LIM   = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] RESET_GATE = DATA_W'(100000000);
	localparam logic [DATA_W-1:0] RESET_RATE = DATA_W'(100000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATE_TICKS = 1'b0,
		CFG_TICK_RATE  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] mcand;
		logic [DATA_W-1:0] mplier;
		logic [DATA_W-1:0] divisor;
	} rfc_req_t;

	typedef struct packed {
		logic              done;
		logic [FREQ_W-1:0] freq;
	} rfc_rsp_t;

endpackage

FILE: hw/rtl/rfc_muldiv.sv
// Bit-serial multiply then restoring divide: freq = floor(mcand*mplier*256/divisor),
// saturated to FREQ_W bits. One bit per cycle in each phase.
// Depends on rfc_pkg.
module rfc_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  rfc_pkg::rfc_req_t req,
	output rfc_pkg::rfc_rsp_t rsp
);
	import rfc_pkg::*;

	typedef enum logic [1:0] {
		U_IDLE,
		U_MUL,
		U_DIV
	} ustate_t;

	ustate_t             state_q;
	logic [DATA_W-1:0]   mcand_q;
	logic [DATA_W-1:0]   divisor_q;
	logic [NUM_W-1:0]    num_q;
	logic [DATA_W-1:0]   rem_q;
	logic [FREQ_W-1:0]   quo_q;
	logic                ovf_q;
	logic [STEP_W-1:0]   step_q;
	logic                done_q;
	logic [FREQ_W-1:0]   freq_q;

	logic [DATA_W:0]     mul_sum;
	logic [DATA_W:0]     rem2;
	logic [DATA_W:0]     rem_sub;
	logic                ge;
	logic                ovf_nx;

	assign mul_sum = {1'b0, num_q[NUM_W-1 -: DATA_W]}
		+ (num_q[FRAC_W] ? {1'b0, mcand_q} : {(DATA_W+1){1'b0}});
	assign rem2    = {rem_q, num_q[NUM_W-1]};
	assign rem_sub = rem2 - {1'b0, divisor_q};
	assign ge      = rem2 >= {1'b0, divisor_q};
	assign ovf_nx  = ovf_q | quo_q[FREQ_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= U_IDLE;
			mcand_q   <= '0;
			divisor_q <= '0;
			num_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			ovf_q     <= 1'b0;
			step_q    <= '0;
			done_q    <= 1'b0;
			freq_q    <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					done_q <= 1'b0;
					if (req.start) begin
						mcand_q   <= req.mcand;
						divisor_q <= req.divisor;
						num_q     <= {{DATA_W{1'b0}}, req.mplier, {FRAC_W{1'b0}}};
						rem_q     <= '0;
						quo_q     <= '0;
						ovf_q     <= 1'b0;
						step_q    <= '0;
						state_q   <= U_MUL;
					end
				end
				U_MUL: begin
					num_q <= {mul_sum, num_q[FRAC_W+DATA_W-1:FRAC_W+1], {FRAC_W{1'b0}}};
					if (step_q == STEP_W'(MUL_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= U_DIV;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				U_DIV: begin
					rem_q <= ge ? rem_sub[DATA_W-1:0] : rem2[DATA_W-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					quo_q <= {quo_q[FREQ_W-2:0], ge};
					ovf_q <= ovf_nx;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						freq_q  <= ovf_nx ? {FREQ_W{1'b1}} : {quo_q[FREQ_W-2:0], ge};
						done_q  <= 1'b1;
						step_q  <= '0;
						state_q <= U_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.freq = freq_q;

endmodule

FILE: hw/rtl/reciprocal_frequency_counter.sv
// Reciprocal frequency counter top level: edge detection, gate timing,
// result sequencing and output register. Depends on rfc_pkg, rfc_muldiv.
//
// channel  dir  handshake         payload
// in       in   in_valid/in_stall pin_level
// out      out  out_valid/out_stall freq_q8, edge_total, span_ticks, valid_res
// cfg      in   cfg_we            cfg_index, cfg_data
//
// One pin sample per cycle while a gate runs.
// The sample that closes a gate holds in_stall while the result is formed: through the
// 32-step serial multiplier and 72-step serial divider when two or more edges were seen,
// through S_PREP and S_LOAD otherwise, longer while the previous word still waits for out_stall.
// A waiting result holds in the output register; new samples keep flowing.
// arst_n clears counters, state and the output word; registers take reset values.
module reciprocal_frequency_counter #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        pin_level,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rfc_pkg::FREQ_W-1:0]  freq_q8,
	output logic [rfc_pkg::DATA_W-1:0]  edge_total,
	output logic [rfc_pkg::DATA_W-1:0]  span_ticks,
	output logic                        valid_res,
	input  logic                        cfg_we,
	input  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfc_pkg::DATA_W-1:0]  cfg_data
);
	import rfc_pkg::*;

	localparam int EW = (COUNT_WIDTH > DATA_W) ? COUNT_WIDTH : DATA_W;

	typedef enum logic [1:0] {
		S_RUN,
		S_PREP,
		S_WAIT,
		S_LOAD
	} state_t;

	state_t                 state_q;
	logic [DATA_W-1:0]      gate_q;
	logic [DATA_W-1:0]      rate_q;
	logic                   prev_q;
	logic [DATA_W-1:0]      elapsed_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [DATA_W-1:0]      first_q;
	logic [DATA_W-1:0]      last_q;

	logic [DATA_W-1:0]      res_edges_q;
	logic [DATA_W-1:0]      res_first_q;
	logic [DATA_W-1:0]      res_last_q;
	logic [DATA_W-1:0]      res_span_q;
	logic                   res_valid_q;
	logic [FREQ_W-1:0]      res_freq_q;

	logic                   out_valid_q;
	logic [FREQ_W-1:0]      out_freq_q;
	logic [DATA_W-1:0]      out_edges_q;
	logic [DATA_W-1:0]      out_span_q;
	logic                   out_res_valid_q;

	logic                   accept;
	logic                   fall;
	logic [COUNT_WIDTH-1:0] count_nx;
	logic [DATA_W-1:0]      first_nx;
	logic [DATA_W-1:0]      last_nx;
	logic [DATA_W-1:0]      elapsed_inc;
	logic [DATA_W-1:0]      gate_len;
	logic                   gate_end;
	logic [EW-1:0]          count_wide;
	logic [DATA_W-1:0]      edges_clip;
	logic                   prep_valid;
	logic [DATA_W-1:0]      prep_span;
	logic                   out_free;
	rfc_req_t               req;
	rfc_rsp_t               rsp;

	assign in_stall    = (state_q != S_RUN);
	assign accept      = in_valid && !in_stall;
	assign fall        = prev_q && !pin_level;
	assign count_nx    = (fall && !(&count_q)) ? count_q + 1'b1 : count_q;
	assign first_nx    = (fall && count_q == '0) ? elapsed_q : first_q;
	assign last_nx     = (fall && count_q != '0) ? elapsed_q : last_q;
	assign elapsed_inc = elapsed_q + 1'b1;
	assign gate_len    = (gate_q == '0) ? DATA_W'(1) : gate_q;
	assign gate_end    = (elapsed_inc == '0) || (elapsed_inc >= gate_len);
	assign count_wide  = EW'(count_nx);
	assign edges_clip  = (count_wide > EW'(EDGE_LIM)) ? EDGE_LIM : count_wide[DATA_W-1:0];

	assign prep_valid  = (res_edges_q >= DATA_W'(2)) && (res_last_q > res_first_q);
	assign prep_span   = res_last_q - res_first_q;
	assign out_free    = !out_valid_q || !out_stall;

	assign req.start   = (state_q == S_PREP) && prep_valid;
	assign req.mcand   = rate_q;
	assign req.mplier  = res_edges_q - 1'b1;
	assign req.divisor = prep_span;

	rfc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= RESET_GATE;
			rate_q <= RESET_RATE;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GATE_TICKS: gate_q <= cfg_data;
				CFG_TICK_RATE:  rate_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b0;
			elapsed_q <= '0;
			count_q   <= '0;
			first_q   <= '0;
			last_q    <= '0;
		end else if (accept) begin
			prev_q <= pin_level;
			if (gate_end) begin
				elapsed_q <= '0;
				count_q   <= '0;
				first_q   <= '0;
				last_q    <= '0;
			end else begin
				elapsed_q <= elapsed_inc;
				count_q   <= count_nx;
				first_q   <= first_nx;
				last_q    <= last_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_RUN;
			res_edges_q     <= '0;
			res_first_q     <= '0;
			res_last_q      <= '0;
			res_span_q      <= '0;
			res_valid_q     <= 1'b0;
			res_freq_q      <= '0;
			out_valid_q     <= 1'b0;
			out_freq_q      <= '0;
			out_edges_q     <= '0;
			out_span_q      <= '0;
			out_res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_RUN: begin
					if (accept && gate_end) begin
						res_edges_q <= edges_clip;
						res_first_q <= first_nx;
						res_last_q  <= last_nx;
						state_q     <= S_PREP;
					end
				end
				S_PREP: begin
					res_valid_q <= prep_valid;
					res_span_q  <= prep_valid ? prep_span : '0;
					res_freq_q  <= '0;
					state_q     <= prep_valid ? S_WAIT : S_LOAD;
				end
				S_WAIT: begin
					if (rsp.done) begin
						res_freq_q <= rsp.freq;
						state_q    <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (out_free) begin
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase

			if (state_q == S_LOAD && out_free) begin
				out_valid_q     <= 1'b1;
				out_freq_q      <= res_freq_q;
				out_edges_q     <= res_edges_q;
				out_span_q      <= res_span_q;
				out_res_valid_q <= res_valid_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign freq_q8    = out_freq_q;
	assign edge_total = out_edges_q;
	assign span_ticks = out_span_q;
	assign valid_res  = out_res_valid_q;

endmodule

FILE: hw/rtl/rfc_checker.sv
// Port-level checks for the reciprocal frequency counter, bound to the top level.
// Depends on rfc_pkg and reciprocal_frequency_counter.
module rfc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [rfc_pkg::FREQ_W-1:0]    freq_q8,
	input logic [rfc_pkg::DATA_W-1:0]    edge_total,
	input logic [rfc_pkg::DATA_W-1:0]    span_ticks,
	input logic                          valid_res
);
	import rfc_pkg::*;

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(freq_q8) && $stable(edge_total)
			&& $stable(span_ticks) && $stable(valid_res))
		else $error("stalled output word changed");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> freq_q8 == '0 && span_ticks == '0)
		else $error("invalid result carries nonzero frequency or span");

	a_valid_edges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> edge_total >= DATA_W'(2) && span_ticks != '0)
		else $error("valid result with fewer than two edges or zero span");

	a_load_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word appeared without a closing gate");

endmodule

bind reciprocal_frequency_counter rfc_checker u_rfc_checker (.*);

FILE: tb/tb_reciprocal_frequency_counter.sv
`timescale 1ns / 100ps
// Testbench for reciprocal_frequency_counter: pin words in, gate reports out,
// each report checked against an in-bench gate predictor or, for typed drill
// rows, a fixed report. Depends on rfc_pkg and the block's RTL only.
module tb_reciprocal_frequency_counter;
	import rfc_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int REST_CYCLES  = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASES       = 8;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DATA_W-1:0] edges;
		logic [DATA_W-1:0] span;
		logic              ok;
	} gate_report_t;

	typedef struct packed {
		logic         pin;
		logic         typed;
		gate_report_t rep;
	} drill_row_t;

	localparam gate_report_t NO_REPORT = '0;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 pin_level = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [FREQ_W-1:0]    freq_q8;
	logic [DATA_W-1:0]    edge_total;
	logic [DATA_W-1:0]    span_ticks;
	logic                 valid_res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_GATE_TICKS;
	logic [DATA_W-1:0]    cfg_data = '0;

	reciprocal_frequency_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.freq_q8(freq_q8),
		.edge_total(edge_total),
		.span_ticks(span_ticks),
		.valid_res(valid_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gate predictor state and settings
	logic [DATA_W-1:0] gate_len = RESET_GATE;
	logic [DATA_W-1:0] rate = RESET_RATE;
	logic              prev_lvl = 1'b0;
	logic [DATA_W-1:0] elapsed = '0;
	logic [DATA_W-1:0] edge_cnt = '0;
	logic [DATA_W-1:0] first_at = '0;
	logic [DATA_W-1:0] last_at = '0;

	gate_report_t pending_reports[$];

	int mismatches = 0;
	int samples_sent = 0;
	int reports_seen = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;

	// pin waveform generator state
	int burst_left = 0;
	int wave_period = 2;
	int wave_high = 1;
	int wave_pos = 0;
	bit noisy = 1'b0;

	drill_row_t drill_rows [16] = '{
		'{1'b1, 1'b0, NO_REPORT}, '{1'b0, 1'b0, NO_REPORT},
		'{1'b1, 1'b0, NO_REPORT}, '{1'b0, 1'b1, '{40'd12800, 32'd2, 32'd2, 1'b1}},
		'{1'b1, 1'b0, NO_REPORT}, '{1'b1, 1'b0, NO_REPORT},
		'{1'b1, 1'b0, NO_REPORT}, '{1'b1, 1'b1, '{40'd0, 32'd0, 32'd0, 1'b0}},
		'{1'b0, 1'b0, NO_REPORT}, '{1'b0, 1'b0, NO_REPORT},
		'{1'b1, 1'b0, NO_REPORT}, '{1'b0, 1'b0, NO_REPORT},
		'{1'b0, 1'b0, NO_REPORT}, '{1'b1, 1'b0, NO_REPORT},
		'{1'b0, 1'b0, NO_REPORT}, '{1'b0, 1'b1, '{40'd0, 32'd1, 32'd0, 1'b0}}
	};

	logic [DATA_W-1:0] phase_gate [PHASES] = '{
		32'd0, 32'd1, 32'd37, 32'hFFFF_FFFF, 32'd16, 32'd64, 32'd0, 32'd8
	};
	logic [DATA_W-1:0] phase_rate [PHASES] = '{
		32'd1, 32'hFFFF_FFFF, 32'd100000000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
		32'hFFFF_FFFF
	};
	bit phase_rand_gate [PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0};
	bit phase_rand_rate [PHASES] = '{0, 0, 0, 0, 0, 1, 1, 0};
	bit phase_hold      [PHASES] = '{0, 0, 0, 0, 0, 0, 0, 1};
	int phase_words     [PHASES] = '{40, 40, 300, 150, 200, 400, 400, 300};
	int phase_send_idle [PHASES] = '{10, 10, 10, 73, 73, 73, 0, 0};
	int phase_recv_idle [PHASES] = '{73, 73, 73, 10, 10, 10, 0, 0};

	function automatic bit advance_gate(input logic pin, output gate_report_t rep);
		logic [DATA_W-1:0] limit;
		logic [DATA_W-1:0] span;
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] quo;
		logic [PROD_W-1:0] rem;
		limit = (gate_len == '0) ? DATA_W'(1) : gate_len;
		rep = NO_REPORT;
		if (prev_lvl && !pin) begin
			if (edge_cnt == '0)
				first_at = elapsed;
			else
				last_at = elapsed;
			if (edge_cnt != EDGE_LIM)
				edge_cnt = edge_cnt + 1'b1;
		end
		prev_lvl = pin;
		elapsed = elapsed + 1'b1;
		if (elapsed != '0 && elapsed < limit)
			return 1'b0;
		rep.edges = edge_cnt;
		if (edge_cnt >= 2 && last_at > first_at) begin
			span = last_at - first_at;
			prod = PROD_W'(edge_cnt - 1'b1) * PROD_W'(rate);
			quo = prod / PROD_W'(span);
			rem = prod % PROD_W'(span);
			if (quo > PROD_W'({FREQ_W{1'b1}} >> FRAC_W))
				rep.freq = {FREQ_W{1'b1}};
			else
				rep.freq = FREQ_W'((quo << FRAC_W) + ((rem << FRAC_W) / PROD_W'(span)));
			rep.span = span;
			rep.ok = 1'b1;
		end
		elapsed = '0;
		edge_cnt = '0;
		first_at = '0;
		last_at = '0;
		return 1'b1;
	endfunction

	// mostly square waves of random period and duty, some bursts of noise
	function automatic logic next_pin();
		logic lvl;
		if (burst_left == 0) begin
			burst_left = $urandom_range(60, 8);
			noisy = ($urandom_range(9) < 2);
			wave_period = $urandom_range(24, 2);
			wave_high = $urandom_range(wave_period - 1, 1);
			wave_pos = $urandom_range(wave_period - 1);
		end
		burst_left--;
		if (noisy)
			return logic'($urandom_range(1));
		lvl = (wave_pos < wave_high);
		wave_pos = (wave_pos + 1) % wave_period;
		return lvl;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0h, got %0h", what, want, got);
	endtask

	task automatic send_pin(input logic pin, input bit typed, input gate_report_t fixed);
		gate_report_t rep;
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pin_level <= pin;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		if (advance_gate(pin, rep))
			pending_reports.push_back(typed ? fixed : rep);
		samples_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_GATE_TICKS)
			gate_len = val;
		else
			rate = val;
		settings_used++;
	endtask

	// let the last gate finish its divide before touching registers
	task automatic drain_and_rest();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (REST_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				flag_mismatch("unexpected report, edge_total", 64'd0, 64'(edge_total));
			end else begin
				gate_report_t want;
				want = pending_reports.pop_front();
				if (freq_q8 !== want.freq)
					flag_mismatch("freq_q8", 64'(want.freq), 64'(freq_q8));
				if (edge_total !== want.edges)
					flag_mismatch("edge_total", 64'(want.edges), 64'(edge_total));
				if (span_ticks !== want.span)
					flag_mismatch("span_ticks", 64'(want.span), 64'(span_ticks));
				if (valid_res !== want.ok)
					flag_mismatch("valid_res", 64'(want.ok), 64'(valid_res));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_reciprocal_frequency_counter: errors");
			$finish;
		end
	end

	initial begin
		logic [DATA_W-1:0] g;
		logic [DATA_W-1:0] r;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 10;
		recv_stall_pct = 73;
		write_reg(CFG_GATE_TICKS, 32'd4);
		write_reg(CFG_TICK_RATE, 32'd100);
		foreach (drill_rows[i])
			send_pin(drill_rows[i].pin, drill_rows[i].typed, drill_rows[i].rep);
		drain_and_rest();

		for (int p = 0; p < PHASES; p++) begin
			g = phase_rand_gate[p] ? DATA_W'($urandom_range(200, 2)) : phase_gate[p];
			r = phase_rand_rate[p] ? DATA_W'($urandom) : phase_rate[p];
			send_idle_pct = phase_send_idle[p];
			recv_stall_pct = phase_recv_idle[p];
			write_reg(CFG_GATE_TICKS, g);
			write_reg(CFG_TICK_RATE, r);
			if (phase_hold[p])
				holds_asked++;
			repeat (phase_words[p])
				send_pin(next_pin(), 1'b0, NO_REPORT);
			drain_and_rest();
		end

		if (pending_reports.size() != 0)
			$display("%0d gate reports never arrived", pending_reports.size());
		$display("covered %0d pin words and %0d gate reports over %0d register writes",
			samples_sent, reports_seen, settings_used);
		$display("gate lengths from 0 to 2^32-1, rates from 0 to 2^32-1, %0d cycles",
			cycle_count);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("tb_reciprocal_frequency_counter: clean");
		else
			$display("tb_reciprocal_frequency_counter: errors");
		$finish;
	end

endmodule
